// File: sv/knn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg: shared constants and types for the knn connected filter
// Frame geometry, neighbour limits, candidate list layout, register codes.
// ----------------------------------------------------------------------------
package knn_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COORD_W    = 8;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int DIM_W      = 9;

  // neighbour limits
  localparam int K_MAX   = 16;
  localparam int K_W     = 5;
  localparam int SUM_W   = 13;

  // candidate list: centre plus four offers per round
  localparam int LIST_DEPTH = 4 * K_MAX + 1;
  localparam int LIST_AW    = $clog2(LIST_DEPTH);

  // register indexes
  localparam logic [1:0] REG_NEIGHBOUR_COUNT = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH     = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd2;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  // one candidate list entry
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [7:0]         v;
  } list_entry_t;

  // absolute difference of two pixels
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: sv/knn_connected_filter_8bit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_connected_filter_8bit_top: 8-bit k-nearest-connected-neighbour filter
// Frame store, result store, candidate list scanned by one compare unit,
// and a restoring divider for the final mean.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each result appears on
// filtered_value, neighbours_used and copied for exactly one cycle with done
// high, and must be taken then since the receiver cannot stall the block.
// A full filter runs in rounds, the candidate list holding the centre at first
// and gaining up to 4 entries per round; its time is set by the candidate
// list memory, which is scanned one entry per cycle for every offered
// neighbour and every selection. The frame and result stores are undefined
// until written.
module knn_connected_filter_8bit_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [7:0] column,
  input  logic [7:0] row,
  input  logic [7:0] pixel_value,
  output logic       done,
  output logic [7:0] filtered_value,
  output logic [4:0] neighbours_used,
  output logic       copied,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import knn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WR    = 4'd1;
  localparam logic [3:0] S_RC    = 4'd2;
  localparam logic [3:0] S_RL    = 4'd3;
  localparam logic [3:0] S_RU    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_RRES  = 4'd6;
  localparam logic [3:0] S_INIT  = 4'd7;
  localparam logic [3:0] S_OREQ  = 4'd8;
  localparam logic [3:0] S_OVAL  = 4'd9;
  localparam logic [3:0] S_OSCAN = 4'd10;
  localparam logic [3:0] S_SSCAN = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam int DCNT_W = $clog2(SUM_W + 1);

  // configuration registers
  logic [K_W-1:0]   neighbour_count;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  // sequencer and item registers
  logic [3:0]         state;
  logic [COORD_W-1:0] col_r, row_r;
  logic [7:0]         centre, left_v, v_r;
  logic [K_W-1:0]     bk, cap, nk;
  logic [COORD_W-1:0] lx, ly, nx_r, ny_r;
  logic [1:0]         dir;
  logic [SUM_W-1:0]   sum;

  // candidate list and scan unit
  list_entry_t            list_mem [LIST_DEPTH];
  list_entry_t            list_q;
  logic [LIST_DEPTH-1:0]  taken;
  logic [LIST_AW-1:0]     lst_n, issue_idx, pend_idx, sel_idx;
  logic                   pend, dup, found;
  logic [K_W-1:0]         cnt;
  logic [8:0]             best_d;
  list_entry_t            sel_e;
  logic                   lst_we;
  logic [LIST_AW-1:0]     lst_waddr;
  list_entry_t            lst_wdata;

  // frame and result stores
  logic [7:0]        frame_store  [MAX_WIDTH*MAX_HEIGHT];
  logic [7:0]        result_store [MAX_WIDTH*MAX_HEIGHT];
  logic [7:0]        frame_q, result_q;
  logic [ADDR_W-1:0] fr_addr, res_addr;
  logic              fr_we, res_we;
  logic [7:0]        res_wdata;

  // divider
  logic [K_W-1:0]    rem;
  logic [K_W:0]      dtmp;
  logic [K_W-1:0]    divisor;
  logic [DCNT_W-1:0] dcnt;

  // derived geometry
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [K_W-1:0]     kk;
  logic signed [10:0] dr, db, dmin;
  logic [K_W-1:0]     bk_calc;
  logic signed [9:0]  nx, ny;
  logic               n_in;
  logic               left_eq, up_eq;
  logic [7:0]         e_d, n_d;
  logic               scan_end;

  assign busy = (state != S_IDLE);

  // saturated frame size and k
  always_comb begin
    w_eff = (frame_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : frame_width;
    h_eff = (frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
    kk    = (neighbour_count > K_W'(K_MAX)) ? K_W'(K_MAX) : neighbour_count;
  end

  // border distance limit on k
  always_comb begin
    dr   = $signed({2'b00, w_eff}) - 11'sd1 - $signed({3'b000, col_r});
    db   = $signed({2'b00, h_eff}) - 11'sd1 - $signed({3'b000, row_r});
    dmin = $signed({3'b000, col_r});
    if (dr < dmin) dmin = dr;
    if ($signed({3'b000, row_r}) < dmin) dmin = $signed({3'b000, row_r});
    if (db < dmin) dmin = db;
    if (dmin < 11'sd0) bk_calc = '0;
    else if (dmin > $signed({6'b0, kk})) bk_calc = kk;
    else bk_calc = dmin[K_W-1:0];
  end

  // neighbour of the last selected pixel
  always_comb begin
    nx = $signed({2'b00, lx});
    ny = $signed({2'b00, ly});
    unique case (dir)
      2'd0: nx = $signed({2'b00, lx}) - 10'sd1;
      2'd1: nx = $signed({2'b00, lx}) + 10'sd1;
      2'd2: ny = $signed({2'b00, ly}) - 10'sd1;
      2'd3: ny = $signed({2'b00, ly}) + 10'sd1;
    endcase
    n_in = !nx[9] && !ny[9] && (nx[8:0] < w_eff) && (ny[8:0] < h_eff);
  end

  // copy checks and diffs
  assign left_eq  = (col_r != '0) && (left_v == centre);
  assign up_eq    = (row_r != '0) && (frame_q == centre);
  assign e_d      = abs_diff(list_q.v, centre);
  assign n_d      = abs_diff(v_r, centre);
  assign scan_end = (issue_idx == lst_n) && !pend;

  // store addresses and write strobes
  always_comb begin
    fr_addr   = {row_r, col_r};
    res_addr  = {row_r - 8'd1, col_r};
    fr_we     = 1'b0;
    res_we    = 1'b0;
    res_wdata = result_q;
    unique case (state)
      S_IDLE:  begin
        fr_addr = {row, column};
        fr_we   = start && (operation == OP_WRITE);
      end
      S_RL:    fr_addr = {row_r, col_r - 8'd1};
      S_RU:    fr_addr = {row_r - 8'd1, col_r};
      S_CHK:   if (left_eq) res_addr = {row_r, col_r - 8'd1};
      S_OREQ:  fr_addr = {ny[7:0], nx[7:0]};
      S_RRES:  res_we = 1'b1;
      S_FIN:   begin
        res_we    = 1'b1;
        res_wdata = sum[7:0];
      end
      default: ;
    endcase
  end

  // candidate list write port
  always_comb begin
    lst_we    = 1'b0;
    lst_waddr = lst_n;
    lst_wdata = '{x: nx_r, y: ny_r, v: v_r};
    if (state == S_INIT) begin
      lst_we    = 1'b1;
      lst_waddr = '0;
      lst_wdata = '{x: col_r, y: row_r, v: centre};
    end else if (state == S_OSCAN && scan_end && !dup && (cnt < cap)) begin
      lst_we = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (fr_we) frame_store[fr_addr] <= pixel_value;
    frame_q <= frame_store[fr_addr];
    if (res_we) result_store[{row_r, col_r}] <= res_wdata;
    result_q <= result_store[res_addr];
    if (lst_we) list_mem[lst_waddr] <= lst_wdata;
    list_q <= list_mem[issue_idx];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_count <= K_W'(8);
      frame_width     <= DIM_W'(MAX_WIDTH);
      frame_height    <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEIGHBOUR_COUNT: neighbour_count <= cfg_data[K_W-1:0];
        REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // divider step
  assign divisor = bk + K_W'(1);
  assign dtmp    = {rem, sum[SUM_W-1]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
      taken <= '0;
      lst_n <= '0;
    end else begin
      done <= 1'b0;
      // shared scan address stepping
      if (state == S_OSCAN || state == S_SSCAN) begin
        if (issue_idx != lst_n) issue_idx <= issue_idx + LIST_AW'(1);
        pend     <= (issue_idx != lst_n);
        pend_idx <= issue_idx;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            col_r <= column;
            row_r <= row;
            state <= (operation == OP_WRITE) ? S_WR : S_RC;
          end
        end
        S_WR: begin
          filtered_value  <= '0;
          neighbours_used <= '0;
          copied          <= 1'b0;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_RC: state <= S_RL;
        S_RL: begin
          centre <= frame_q;
          state  <= S_RU;
        end
        S_RU: begin
          left_v <= frame_q;
          state  <= S_CHK;
        end
        S_CHK: begin
          bk    <= bk_calc;
          cap   <= kk + K_W'(2);
          state <= (left_eq || up_eq) ? S_RRES : S_INIT;
        end
        S_RRES: begin
          filtered_value  <= result_q;
          neighbours_used <= '0;
          copied          <= 1'b1;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_INIT: begin
          taken    <= LIST_DEPTH'(1);
          lst_n    <= LIST_AW'(1);
          sum      <= SUM_W'(centre);
          lx       <= col_r;
          ly       <= row_r;
          nk       <= K_W'(1);
          dir      <= 2'd0;
          rem      <= '0;
          dcnt     <= '0;
          state    <= (bk == '0) ? S_DIV : S_OREQ;
        end
        S_OREQ: begin
          if (n_in) begin
            nx_r  <= nx[7:0];
            ny_r  <= ny[7:0];
            state <= S_OVAL;
          end else if (dir == 2'd3) begin
            issue_idx <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            best_d    <= 9'd256;
            state     <= S_SSCAN;
          end else begin
            dir <= dir + 2'd1;
          end
        end
        S_OVAL: begin
          v_r       <= frame_q;
          issue_idx <= '0;
          pend      <= 1'b0;
          dup       <= 1'b0;
          cnt       <= '0;
          state     <= S_OSCAN;
        end
        S_OSCAN: begin
          if (pend) begin
            if (list_q.x == nx_r && list_q.y == ny_r) dup <= 1'b1;
            if (e_d == n_d) cnt <= cnt + K_W'(1);
          end
          if (scan_end) begin
            if (!dup && (cnt < cap)) lst_n <= lst_n + LIST_AW'(1);
            // pend is already low here from the address stepping
            if (dir == 2'd3) begin
              issue_idx <= '0;
              found     <= 1'b0;
              best_d    <= 9'd256;
              state     <= S_SSCAN;
            end else begin
              dir   <= dir + 2'd1;
              state <= S_OREQ;
            end
          end
        end
        S_SSCAN: begin
          // least diff among untaken, earliest wins a tie
          if (pend && !taken[pend_idx] && ({1'b0, e_d} < best_d)) begin
            best_d  <= {1'b0, e_d};
            sel_idx <= pend_idx;
            sel_e   <= list_q;
            found   <= 1'b1;
          end
          if (scan_end) begin
            if (!found || nk == bk) state <= S_DIV;
            else state <= S_OREQ;
            if (found) begin
              taken[sel_idx] <= 1'b1;
              sum <= sum + SUM_W'(sel_e.v);
              lx  <= sel_e.x;
              ly  <= sel_e.y;
            end
            nk  <= nk + K_W'(1);
            dir <= 2'd0;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle into sum
          if (dtmp >= {1'b0, divisor}) begin
            rem <= K_W'(dtmp - {1'b0, divisor});
            sum <= {sum[SUM_W-2:0], 1'b1};
          end else begin
            rem <= dtmp[K_W-1:0];
            sum <= {sum[SUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(SUM_W - 1)) state <= S_FIN;
        end
        S_FIN: begin
          filtered_value  <= sum[7:0];
          neighbours_used <= bk;
          copied          <= 1'b0;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a word in work");

  a_copy_no_k: assert property (@(posedge clk) disable iff (rst)
    (done && copied) |-> (neighbours_used == '0))
    else $error("copied result reports neighbours");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    lst_n <= LIST_AW'(LIST_DEPTH))
    else $error("candidate list overflow");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OSCAN || state == S_SSCAN) |-> (issue_idx <= lst_n))
    else $error("scan address beyond list fill");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (neighbours_used <= K_W'(K_MAX)))
    else $error("effective k above limit");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for knn_connected_filter_8bit_top
// Loads pixels, filters them under several k and frame settings, and checks
// every result word against a local predictor of the connected-region mean.
// ----------------------------------------------------------------------------
module testbench;
  import knn_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  localparam int SLOTS      = K_MAX + 2;

  typedef struct {
    logic [7:0] fv;
    logic [4:0] nu;
    logic       cp;
  } word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       operation = OP_WRITE;
  logic [7:0] column = '0;
  logic [7:0] row = '0;
  logic [7:0] pixel_value = '0;
  logic       done;
  logic [7:0] filtered_value;
  logic [4:0] neighbours_used;
  logic       copied;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_NEIGHBOUR_COUNT;
  logic [8:0] cfg_data = '0;

  knn_connected_filter_8bit_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] pixels [65536];
  bit         pixel_known [65536];
  logic [7:0] filtered [65536];
  bit         filtered_known [65536];
  int         k_reg = 8, width_reg = 256, height_reg = 256;
  // region growth scratch
  int cand_x [256][SLOTS];
  int cand_y [256][SLOTS];
  int fill [256];
  int taken [256];
  int best, cur_w, cur_h, centre_val, cap;
  bit reads_ok;

  word_t pending [$];
  int    errors = 0;
  int    sent = 0;
  int    burst_left = 0;

  function automatic int read_pixel(int x, int y);
    if (!pixel_known[y * 256 + x]) reads_ok = 0;
    return int'(pixels[y * 256 + x]);
  endfunction

  function automatic int read_filtered(int x, int y);
    if (!filtered_known[y * 256 + x]) reads_ok = 0;
    return int'(filtered[y * 256 + x]);
  endfunction

  // add one neighbour to its diff bucket
  function automatic void offer_pixel(int x, int y);
    int v, d, n;
    if (x < 0 || y < 0 || x >= cur_w || y >= cur_h) return;
    v = read_pixel(x, y);
    d = (v > centre_val) ? v - centre_val : centre_val - v;
    n = fill[d];
    for (int i = 0; i < n && i < SLOTS; i++)
      if (cand_x[d][i] == x && cand_y[d][i] == y) return;
    if (n >= cap || n >= SLOTS) return;
    cand_x[d][n] = x;
    cand_y[d][n] = y;
    fill[d] = n + 1;
    if (d < best) best = d;
  endfunction

  // expected word for a filter of (c,r); ok is low if it reads unwritten data
  function automatic void predict_filter(input int c, input int r, output word_t o,
                                         output bit ok);
    int kk, bk, sum, lx, ly, t;
    reads_ok = 1;
    o = '{fv: '0, nu: '0, cp: 1'b0};
    centre_val = read_pixel(c, r);
    if ((c > 0 && read_pixel(c - 1, r) == centre_val) ||
        (r > 0 && read_pixel(c, r - 1) == centre_val)) begin
      if (c > 0 && pixels[r * 256 + c - 1] == centre_val) o.fv = 8'(read_filtered(c - 1, r));
      else o.fv = 8'(read_filtered(c, r - 1));
      o.cp = 1'b1;
      ok = reads_ok;
      return;
    end
    cur_w = (width_reg < MAX_WIDTH) ? width_reg : MAX_WIDTH;
    cur_h = (height_reg < MAX_HEIGHT) ? height_reg : MAX_HEIGHT;
    kk = (k_reg < K_MAX) ? k_reg : K_MAX;
    bk = c;
    if (cur_w - 1 - c < bk) bk = cur_w - 1 - c;
    if (r < bk) bk = r;
    if (cur_h - 1 - r < bk) bk = cur_h - 1 - r;
    if (bk < 0) bk = 0;
    if (kk < bk) bk = kk;
    cap = kk + 2;
    for (int i = 0; i < 256; i++) begin
      fill[i] = 0;
      taken[i] = 0;
    end
    cand_x[0][0] = c;
    cand_y[0][0] = r;
    fill[0] = 1;
    taken[0] = 1;
    lx = c;
    ly = r;
    sum = centre_val;
    best = 1000;
    for (int nk = 1; nk <= bk; nk++) begin
      offer_pixel(lx - 1, ly);
      offer_pixel(lx + 1, ly);
      offer_pixel(lx, ly - 1);
      offer_pixel(lx, ly + 1);
      while (best < 256 && taken[best] >= fill[best]) best++;
      if (best >= 256) break;
      t = taken[best];
      if (t >= SLOTS) break;
      lx = cand_x[best][t];
      ly = cand_y[best][t];
      taken[best] = t + 1;
      sum += read_pixel(lx, ly);
    end
    o.fv = 8'(sum / (bk + 1));
    o.nu = 5'(bk);
    ok = reads_ok;
  endfunction

  // drive one word and wait until the block takes it
  task automatic send_word(input logic op, input int c, input int r, input int v);
    int gap;
    start <= 1'b1;
    operation <= op;
    column <= 8'(c);
    row <= 8'(r);
    pixel_value <= 8'(v);
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_pixel(input int c, input int r, input int v);
    pixels[r * 256 + c] = 8'(v);
    pixel_known[r * 256 + c] = 1;
    pending.push_back('{fv: '0, nu: '0, cp: 1'b0});
    send_word(OP_WRITE, c, r, v);
  endtask

  // filter only where every read hits written data
  task automatic filter_pixel(input int c, input int r);
    word_t o;
    bit ok;
    predict_filter(c, r, o, ok);
    if (!ok) return;
    filtered[r * 256 + c] = o.fv;
    filtered_known[r * 256 + c] = 1;
    pending.push_back(o);
    send_word(OP_FILTER, c, r, $urandom_range(0, 255));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic set_reg(input logic [1:0] idx, input int val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 9'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_NEIGHBOUR_COUNT: k_reg = val & 5'h1f;
      REG_FRAME_WIDTH:     width_reg = val & 9'h1ff;
      default:             height_reg = val & 9'h1ff;
    endcase
  endtask

  function automatic int pick_value(input int mode);
    case (mode)
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(0, 255);
      default: return ($urandom_range(0, 1) ? 255 : 0) ^ $urandom_range(0, 1);
    endcase
  endfunction

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    word_t e;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        report("unexpected word", 0, int'(filtered_value));
      end else begin
        e = pending.pop_front();
        if (filtered_value !== e.fv)
          report("filtered_value", int'(e.fv), int'(filtered_value));
        if (neighbours_used !== e.nu)
          report("neighbours_used", int'(e.nu), int'(neighbours_used));
        if (copied !== e.cp) report("copied", int'(e.cp), int'(copied));
      end
    end
  end

  // watchdog on cycles with no handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // corners, copies and store extremes at reset settings
  task automatic test_reset_settings();
    write_pixel(0, 0, 0);
    write_pixel(1, 0, 255);
    filter_pixel(0, 0);
    filter_pixel(1, 0);
    write_pixel(0, 1, 0);
    filter_pixel(0, 1);
    write_pixel(1, 1, 255);
    filter_pixel(1, 1);
    write_pixel(254, 254, 170);
    write_pixel(255, 254, 85);
    write_pixel(254, 253, 1);
    write_pixel(255, 253, 2);
    write_pixel(254, 255, 85);
    write_pixel(255, 255, 85);
    filter_pixel(255, 253);
    filter_pixel(255, 254);
    filter_pixel(255, 255);
  endtask

  // one setting: load a block of pixels, raster filter it if raster is set, then random filters and writes
  task automatic run_phase(input int k, input int fw, input int fh, input int sx,
                           input int sy, input int mode, input bit raster,
                           input int nrand);
    set_reg(REG_NEIGHBOUR_COUNT, k);
    set_reg(REG_FRAME_WIDTH, fw);
    set_reg(REG_FRAME_HEIGHT, fh);
    for (int y = 0; y < sy; y++)
      for (int x = 0; x < sx; x++)
        write_pixel(x, y, pick_value((mode == 3) ? $urandom_range(0, 2) : mode));
    if (raster)
      for (int y = 0; y < sy; y++)
        for (int x = 0; x < sx; x++)
          filter_pixel(x, y);
    for (int i = 0; i < nrand; i++) begin
      if ($urandom_range(0, 3) == 0) write_pixel($urandom_range(0, sx - 1),
                                                 $urandom_range(0, sy - 1),
                                                 pick_value(1));
      filter_pixel($urandom_range(0, sx - 1), $urandom_range(0, sy - 1));
    end
  endtask

  task automatic test_setting_extremes();
    run_phase(0, 8, 8, 9, 9, 0, 1, 10);
    run_phase(1, 1, 1, 3, 3, 1, 1, 5);
    run_phase(3, 0, 5, 4, 6, 2, 1, 5);
    run_phase(31, 511, 6, 20, 6, 3, 1, 20);
    run_phase(2, 6, 511, 6, 12, 3, 1, 10);
    run_phase(16, 33, 33, 33, 33, 3, 0, 60);
  endtask

  task automatic test_random_frames();
    while (sent < 1600) begin
      run_phase($urandom_range(0, 31), $urandom_range(1, 14), $urandom_range(1, 14),
                $urandom_range(3, 15), $urandom_range(3, 15), $urandom_range(0, 3),
                $urandom_range(0, 3) != 0, $urandom_range(5, 30));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_setting_extremes();
    test_random_frames();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
